FILE: rtl/adq_pkg.sv
package adq_pkg;

    localparam int WINDOW_DEPTH = 16;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 15;
    localparam int SUM_W    = 20;
    localparam int LEN_W    = 5;
    localparam int FRAC_SH  = 15;
    localparam int BOUND_W  = 32 - FRAC_SH;
    localparam int LPROD_W  = LEN_W + STEP_W;

    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int DEP_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_A = (DEP_W > LEN_W) ? DEP_W : LEN_W;
    localparam int CMP_W = (CMP_A > POS_W + 1) ? CMP_A : POS_W + 1;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);
    localparam logic [STEP_W-1:0] SEARCH_LO  = STEP_W'(1);
    localparam logic [STEP_W-1:0] SEARCH_HI  = STEP_W'(32767);

    localparam logic signed [SAMPLE_W-1:0] GAIN_RESET  = '0;
    localparam logic [STEP_W-1:0]          SCALE_RESET = STEP_W'(32767);
    localparam logic [LEN_W-1:0]           LEN_RESET   = LEN_W'(10);

    typedef enum logic [1:0] {
        CFG_PREDICTOR_GAIN = 2'd0,
        CFG_STEP_SCALE     = 2'd1,
        CFG_WINDOW_LENGTH  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] code;
        logic                       last_of_block;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] predictor_gain;
        logic [STEP_W-1:0]          step_scale;
        logic [LEN_W-1:0]           window_length;
    } cfg_t;

endpackage

FILE: rtl/adq_front.sv
module adq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  adq_pkg::item_t s_item,
    output logic          q_valid,
    input  logic          q_ready,
    output adq_pkg::item_t q_item
);
    import adq_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

FILE: rtl/adq_back.sv
module adq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  adq_pkg::item_t q_item,
    input  adq_pkg::cfg_t  cfg,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [adq_pkg::SAMPLE_W-1:0] m_sample,
    output logic          m_last
);
    import adq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SCALE,
        S_SEARCH
    } state_t;

    state_t                      state_reg, state_next;
    logic [SAMPLE_W-1:0]         diff_reg, diff_next;
    logic signed [31:0]          gprod_reg, gprod_next;
    logic                        last_reg, last_next;
    logic [SAMPLE_W-1:0]         pred_reg, pred_next;
    logic signed [SAMPLE_W-1:0]  prev_reg, prev_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [SAMPLE_W-1:0]         win_reg [WINDOW_DEPTH];
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [BOUND_W-1:0]          bound_reg, bound_next;
    logic [STEP_W-1:0]           lo_reg, lo_next;
    logic [STEP_W-1:0]           hi_reg, hi_next;
    logic [STEP_W-1:0]           s_reg, s_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         out_sample_reg, out_sample_next;
    logic                        out_last_reg, out_last_next;

    logic signed [31:0]          code_prod;
    logic signed [31:0]          gain_prod;
    logic signed [31:0]          frac_adj;
    logic [SAMPLE_W-1:0]         sample;
    logic [SAMPLE_W-1:0]         mag;
    logic [SAMPLE_W-1:0]         win_old;
    logic                        upd_fire;
    logic [CMP_W-1:0]            len_ext;
    logic [CMP_W-1:0]            ring_len;
    logic [CMP_W-1:0]            pos_inc;
    logic [SUM_W+STEP_W-1:0]     scale_prod;
    logic [LPROD_W-1:0]          len_prod;
    logic                        over;
    logic [STEP_W:0]             mid_sum;

    assign q_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_sample = out_sample_reg;
    assign m_last   = out_last_reg;

    assign code_prod = q_item.code * $signed({1'b0, step_reg});
    assign gain_prod = cfg.predictor_gain * prev_reg;

    // division by 2^15 rounding toward zero
    assign frac_adj = gprod_reg[31] ? (gprod_reg + 32'sd32767) : gprod_reg;
    assign sample   = diff_reg + pred_reg;
    assign mag      = diff_reg[SAMPLE_W-1] ? (SAMPLE_W'(0) - diff_reg) : diff_reg;
    assign win_old  = win_reg[pos_reg];
    assign upd_fire = (state_reg == S_UPDATE) && (!out_valid_reg || m_ready);

    assign len_ext  = CMP_W'(cfg.window_length);
    assign ring_len = (len_ext < CMP_W'(WINDOW_DEPTH)) ? len_ext : CMP_W'(WINDOW_DEPTH);
    assign pos_inc  = CMP_W'(pos_reg) + CMP_W'(1);

    assign scale_prod = sum_reg * cfg.step_scale;
    assign len_prod   = cfg.window_length * s_reg;
    assign over       = len_prod > LPROD_W'(bound_reg);

    always_comb
    begin
        state_next      = state_reg;
        diff_next       = diff_reg;
        gprod_next      = gprod_reg;
        last_next       = last_reg;
        pred_next       = pred_reg;
        prev_next       = prev_reg;
        step_next       = step_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        bound_next      = bound_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        s_next          = s_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        mid_sum         = {1'b0, lo_reg} + {1'b0, hi_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    diff_next  = code_prod[SAMPLE_W-1:0];
                    gprod_next = gain_prod;
                    last_next  = q_item.last_of_block;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (upd_fire)
                begin
                    pred_next       = sample - frac_adj[FRAC_SH+SAMPLE_W-1:FRAC_SH];
                    prev_next       = $signed(sample);
                    sum_next        = sum_reg - SUM_W'(win_old) + SUM_W'(mag);
                    pos_next        = (pos_inc >= ring_len) ? '0 : pos_inc[POS_W-1:0];
                    out_valid_next  = 1'b1;
                    out_sample_next = sample;
                    out_last_next   = last_reg;
                    state_next      = S_SCALE;
                end
            end
            S_SCALE:
            begin
                bound_next = scale_prod[31:FRAC_SH];
                lo_next    = SEARCH_LO;
                hi_next    = SEARCH_HI;
                s_next     = STEP_W'((STEP_W+1)'(SEARCH_LO) + (STEP_W+1)'(SEARCH_HI) >> 1);
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                // one bisection round per cycle
                lo_next = over ? lo_reg : s_reg;
                hi_next = over ? s_reg : hi_reg;
                mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
                s_next  = mid_sum[STEP_W:1];
                if (s_next == lo_next)
                begin
                    step_next  = s_next;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            diff_reg       <= '0;
            gprod_reg      <= '0;
            last_reg       <= 1'b0;
            pred_reg       <= '0;
            prev_reg       <= '0;
            step_reg       <= STEP_RESET;
            sum_reg        <= '0;
            pos_reg        <= '0;
            bound_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            s_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            diff_reg       <= diff_next;
            gprod_reg      <= gprod_next;
            last_reg       <= last_next;
            pred_reg       <= pred_next;
            prev_reg       <= prev_next;
            step_reg       <= step_next;
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            bound_reg      <= bound_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            s_reg          <= s_next;
            out_valid_reg  <= out_valid_next;
            out_sample_reg <= out_sample_next;
            out_last_reg   <= out_last_next;
            if (upd_fire)
            begin
                win_reg[pos_reg] <= mag;
            end
        end
    end

endmodule

FILE: rtl/adaptive_step_dequantizer.sv
// adaptive step dequantizer, one channel
//
// s_axis: one quantized code per request, tlast marks the last code of a block
// m_axis: one reconstructed sample per code, tlast copied from the input
// cfg:    register writes (0 predictor gain, 1 step scale, 2 window length),
//         taken every cycle; write only while no code is in flight
//
// a two-entry input queue takes codes while the back end works; the back end
// runs one code at a time: multiply, sample/window update, sum scaling, then
// 14 to 15 bisection rounds for the next step. a code taken on s_axis passes
// the queue entry, the multiply registers and the output register, the last
// loaded in the update state, so the sample shows up on m_axis before the step
// search has finished.
// the output register holds a sample until taken; a stalled receiver stops the
// back end before its update cycle, and the queue then fills and drops tready.
// reset clears prediction, step (to 1), window sum, all window entries and the
// registers to their defaults (gain 0, scale 32767, length 10).
module adaptive_step_dequantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import adq_pkg::*;

    cfg_t  cfg_reg;
    item_t s_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    assign cfg_ready          = 1'b1;
    assign s_item.code          = $signed(s_axis_tdata);
    assign s_item.last_of_block = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.predictor_gain <= GAIN_RESET;
            cfg_reg.step_scale     <= SCALE_RESET;
            cfg_reg.window_length  <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PREDICTOR_GAIN: cfg_reg.predictor_gain <= $signed(cfg_data);
                CFG_STEP_SCALE:     cfg_reg.step_scale     <= cfg_data[STEP_W-1:0];
                CFG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    adq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    adq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .cfg      (cfg_reg),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_sample (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

    // a full queue always has a code to hand over
    a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_valid)
        else $error("input queue full but empty toward back end");

    // back end works on one code at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> !q_ready)
        else $error("back end took a second code while busy");

    a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == CFG_WINDOW_LENGTH))
        |=> (cfg_reg.window_length == $past(cfg_data[LEN_W-1:0])))
        else $error("window length write lost");

endmodule
